// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file bvcg_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: rtl/core/bvcg_pkg.sv
`default_nettype none

package bvcg_pkg;

    localparam int unsigned NUM_READINGS = 16;

    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int unsigned SLOT_W    = (NUM_READINGS > 1) ? $clog2(NUM_READINGS) : 1;
    localparam int unsigned SUM_W     = $clog2(NUM_READINGS * SAMPLE_MAX + 1);

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned VOLT_W    = 16;
    localparam int unsigned PCT_W     = 7;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLTAGE_MV  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLTAGE_MV  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR_Q8 = 2'd3;

    // pin = avg * 3200 / 4096
    localparam int unsigned PIN_MUL    = 3200;
    localparam int unsigned PIN_SHIFT  = 12;
    localparam int unsigned PIN_PROD_W = SAMPLE_W + 12;
    localparam int unsigned Q_FRAC     = 8;
    localparam int unsigned VPROD_W    = SAMPLE_W + CFG_W;

    // floor(x / 100) = (x * 83887) >> 23, exact for all 16-bit x
    localparam int unsigned PCT_MAX     = 100;
    localparam int unsigned MIN_RANGE   = 100;
    localparam int unsigned RECIP_100   = 83887;
    localparam int unsigned RECIP_SHIFT = 23;
    localparam int unsigned RPROD_W     = CFG_W + 17;

    localparam int unsigned DIV_W   = 16;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/bvcg_ram.sv
`default_nettype none

module bvcg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bvcg_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module bvcg_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bvcg_pkg::div_req_t req,
    output bvcg_pkg::div_rsp_t      rsp
);

    import bvcg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;

    logic [DIV_W:0]       shifted;
    logic [DIV_W+1:0]     trial;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // borrow means the trial subtract failed
            if (trial[DIV_W+1])
            begin
                rem_next = shifted[DIV_W-1:0];
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            quo_next = {quo_reg[DIV_W-2:0], ~trial[DIV_W+1]};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/battery_voltage_charge_gauge_top.sv
`default_nettype none

// Moving-average battery gauge. Each 12-bit converter word on s_* goes into a
// 16-entry sample RAM; zero entries are empty slots, and all slots read as
// empty after reset (per-slot valid flops, no clearing pass). A word that
// fills an empty slot gives no result. Otherwise the block returns the
// averaged voltage in mV and the charge percent on m_*; the percent is settled
// either by the range checks or by the bit-serial divider, the longer path.
// With the sensor disabled a zero result is returned and the RAM is left
// alone. One word is worked at a time; a new word is taken while the
// previous result waits in the output register. Write configuration only
// while the block is idle.
module battery_voltage_charge_gauge_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [bvcg_pkg::IN_TDATA_W-1:0]    s_tdata,   // [11:0] adc_sample
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [bvcg_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [15:0] voltage_mv,
                                                               // [22:16] charge_percent
    input  wire logic                               cfg_we,
    input  wire logic [bvcg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bvcg_pkg::CFG_W-1:0]         cfg_data
);

    import bvcg_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_AVG    = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_CHK    = 3'd4;
    localparam logic [2:0] S_DSTART = 3'd5;
    localparam logic [2:0] S_DWAIT  = 3'd6;
    localparam logic [2:0] S_PUB    = 3'd7;

    logic [2:0]              state_reg, state_next;

    logic                    enabled_reg;
    logic [CFG_W-1:0]        min_mv_reg;
    logic [CFG_W-1:0]        max_mv_reg;
    logic [CFG_W-1:0]        scale_reg;

    logic [NUM_READINGS-1:0] filled_reg, filled_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [SAMPLE_W-1:0]     sample_reg, sample_next;
    logic [SAMPLE_W-1:0]     pin_reg, pin_next;
    logic [VOLT_W-1:0]       volt_reg, volt_next;
    logic [PCT_W-1:0]        pct_reg, pct_next;
    logic [CFG_W-1:0]        num_reg, num_next;
    logic [CFG_W-1:0]        step_reg, step_next;

    logic                    out_valid_reg, out_valid_next;
    logic [VOLT_W-1:0]       out_volt_reg, out_volt_next;
    logic [PCT_W-1:0]        out_pct_reg, out_pct_next;

    logic                    in_accept;
    logic [SAMPLE_W-1:0]     ram_rdata;
    logic [SAMPLE_W-1:0]     old_sample;
    logic [SAMPLE_W-1:0]     avg;
    logic [PIN_PROD_W-1:0]   pin_prod;
    logic [VPROD_W-1:0]      vprod;
    logic [CFG_W-1:0]        range;
    logic [RPROD_W-1:0]      rprod;
    logic                    out_free;

    div_req_t                div_req;
    div_rsp_t                div_rsp;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    bvcg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NUM_READINGS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (state_reg == S_READ),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_en   (in_accept && enabled_reg),
        .rd_addr (slot_reg),
        .rd_data (ram_rdata)
    );

    assign div_req.start    = (state_reg == S_DSTART);
    assign div_req.dividend = num_reg;
    assign div_req.divisor  = step_reg;

    bvcg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // slot never written since reset reads as empty
    assign old_sample = filled_reg[slot_reg] ? ram_rdata : '0;
    assign avg        = SAMPLE_W'(sum_reg / SUM_W'(NUM_READINGS));
    assign pin_prod   = PIN_PROD_W'(avg) * PIN_PROD_W'(PIN_MUL);
    assign vprod      = VPROD_W'(pin_reg) * VPROD_W'(scale_reg);
    assign range      = max_mv_reg - min_mv_reg;
    assign rprod      = RPROD_W'(range) * RPROD_W'(RECIP_100);

    always_comb
    begin
        state_next     = state_reg;
        filled_next    = filled_reg;
        slot_next      = slot_reg;
        sum_next       = sum_reg;
        sample_next    = sample_reg;
        pin_next       = pin_reg;
        volt_next      = volt_reg;
        pct_next       = pct_reg;
        num_next       = num_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_volt_next  = out_volt_reg;
        out_pct_next   = out_pct_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = s_tdata[SAMPLE_W-1:0];
                    if (enabled_reg)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        volt_next  = '0;
                        pct_next   = '0;
                        state_next = S_PUB;
                    end
                end
            end
            S_READ:
            begin
                filled_next[slot_reg] = 1'b1;
                sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
                if (slot_reg == SLOT_W'(NUM_READINGS - 1))
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
                state_next = (old_sample == '0) ? S_IDLE : S_AVG;
            end
            S_AVG:
            begin
                pin_next   = SAMPLE_W'(pin_prod >> PIN_SHIFT);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (|vprod[VPROD_W-1:Q_FRAC+VOLT_W])
                begin
                    volt_next = '1;
                end
                else
                begin
                    volt_next = vprod[Q_FRAC+VOLT_W-1:Q_FRAC];
                end
                state_next = S_CHK;
            end
            S_CHK:
            begin
                num_next  = volt_reg - min_mv_reg;
                step_next = CFG_W'(rprod >> RECIP_SHIFT);
                if (max_mv_reg >= min_mv_reg && range < CFG_W'(MIN_RANGE))
                begin
                    pct_next   = '0;
                    state_next = S_PUB;
                end
                else if (volt_reg < min_mv_reg)
                begin
                    pct_next   = '0;
                    state_next = S_PUB;
                end
                else if (volt_reg > max_mv_reg)
                begin
                    pct_next   = PCT_W'(PCT_MAX);
                    state_next = S_PUB;
                end
                else
                begin
                    state_next = S_DSTART;
                end
            end
            S_DSTART:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient > DIV_W'(PCT_MAX))
                    begin
                        pct_next = PCT_W'(PCT_MAX);
                    end
                    else
                    begin
                        pct_next = div_rsp.quotient[PCT_W-1:0];
                    end
                    state_next = S_PUB;
                end
            end
            S_PUB:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_volt_next  = volt_reg;
                    out_pct_next   = pct_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            filled_reg    <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            enabled_reg   <= 1'b0;
            min_mv_reg    <= '0;
            max_mv_reg    <= '0;
            scale_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            slot_reg      <= slot_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SENSOR_ENABLED:  enabled_reg <= cfg_data[0];
                    REG_MIN_VOLTAGE_MV:  min_mv_reg  <= cfg_data;
                    REG_MAX_VOLTAGE_MV:  max_mv_reg  <= cfg_data;
                    REG_SCALE_FACTOR_Q8: scale_reg   <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        pin_reg      <= pin_next;
        volt_reg     <= volt_next;
        pct_reg      <= pct_next;
        num_reg      <= num_next;
        step_reg     <= step_next;
        out_volt_reg <= out_volt_next;
        out_pct_reg  <= out_pct_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - VOLT_W - PCT_W)'(0), out_pct_reg, out_volt_reg};

endmodule

`default_nettype wire

// File: rtl/core/bvcg_chk.sv
`default_nettype none

`include "assert_macros.svh"

module bvcg_chk (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [bvcg_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    import bvcg_pkg::*;

    // held result word must not change until taken
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one word in flight: input closes right after an accept
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // percent field stays within 0..100
    `ASSERT_SAME(a_pct_range, clk, rst_n, m_tvalid, m_tdata[22:16] <= 7'(PCT_MAX))

    // padding bit is zero
    `ASSERT_SAME(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[23] == 1'b0)

endmodule

bind battery_voltage_charge_gauge_top bvcg_chk u_bvcg_chk (.*);

`default_nettype wire
